// File: rtl/dte_pkg.sv
// ----------------------------------------------------------------------------
// dte_pkg: shared types and constants of the dictionary token expander
// Command format handed from the front end to the back end, load status
// codes and the default sizes of the block.
// ----------------------------------------------------------------------------
package dte_pkg;

   localparam int DICT_DEPTH_DEF    = 4096;
   localparam int MAX_TOKENS_DEF    = 128;
   localparam int MAX_ENTRY_LEN_DEF = 64;
   localparam int QUEUE_DEPTH_DEF   = 4;

   // store address field wide enough for the largest dictionary store
   localparam int ADDR_W  = 16;
   localparam int IDX_W   = 7;
   localparam int LEN_W   = 7;
   localparam int LIMIT_W = 12;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd255;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_TOO_MANY = 3'd1,
      ST_TOO_LONG = 3'd2,
      ST_TRUNC    = 3'd3,
      ST_OVERFLOW = 3'd4
   } load_status_type;

   typedef struct packed {
      logic                  is_clue;
      logic [7:0]            data;
      logic                  first;
      logic                  last;
      logic                  store_wr;
      logic [ADDR_W-1:0]     store_addr;
      logic                  entry_wr;
      logic [IDX_W-1:0]      entry_idx;
      logic [ADDR_W-1:0]     entry_off;
      logic [LEN_W-1:0]      entry_len;
      logic                  dict_clear;
      logic                  status_vld;
      load_status_type       status;
      logic [7:0]            new_count;
   } dte_cmd_type;

endpackage

// File: rtl/dte_req_if.sv
// ----------------------------------------------------------------------------
// dte_req_if: input item channel
// Valid/ready channel carrying one blob byte or clue byte per item.
// ----------------------------------------------------------------------------
interface dte_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] data_byte;
   logic       first;
   logic       last;

   modport source (output valid, opcode, data_byte, first, last, input ready);
   modport sink   (input valid, opcode, data_byte, first, last, output ready);
endinterface

// File: rtl/dte_rsp_if.sv
// ----------------------------------------------------------------------------
// dte_rsp_if: result item channel
// Valid/ready channel carrying one expanded byte, marker or load status.
// ----------------------------------------------------------------------------
interface dte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       end_of_clue;
   logic [2:0] load_status;
   logic       status_valid;
   logic       last_of_run;

   modport source (output valid, out_byte, has_byte, end_of_clue, load_status,
                   status_valid, last_of_run, input ready);
   modport sink   (input valid, out_byte, has_byte, end_of_clue, load_status,
                   status_valid, last_of_run, output ready);
endinterface

// File: rtl/dte_front.sv
// ----------------------------------------------------------------------------
// dte_front: item intake and blob parser
// Accepts items, tracks the blob parse and turns every item into a command.
// ----------------------------------------------------------------------------
module dte_front
   import dte_pkg::*;
#(
   parameter int DICT_DEPTH    = DICT_DEPTH_DEF,
   parameter int MAX_TOKENS    = MAX_TOKENS_DEF,
   parameter int MAX_ENTRY_LEN = MAX_ENTRY_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   dte_req_if.sink     req,
   input  logic        q_full,
   output logic        push,
   output dte_cmd_type cmd_out
);

   localparam int AW = $clog2(DICT_DEPTH);
   localparam int PW = AW + 1;
   localparam int LW = $clog2(MAX_ENTRY_LEN + 1);

   logic [PW-1:0]   pos_ff, pos_in;
   logic [7:0]      parsed_ff, parsed_in;
   logic [LW-1:0]   left_ff, left_in;
   load_status_type err_ff, err_in;
   logic [7:0]      count_ff, count_in;

   logic            start;
   logic [PW-1:0]   pos;
   logic [7:0]      b;
   load_status_type status;

   assign req.ready = !q_full;
   assign push      = req.valid && req.ready;
   assign b         = req.data_byte;

   always_comb begin
      start     = req.first || (pos_ff == '0);
      pos       = start ? '0 : pos_ff;
      parsed_in = start ? '0 : parsed_ff;
      left_in   = start ? '0 : left_ff;
      err_in    = start ? ST_OK : err_ff;
      count_in  = count_ff;
      pos_in    = pos;
      status    = ST_OK;
      cmd_out   = '0;

      cmd_out.data  = b;
      cmd_out.first = req.first;
      cmd_out.last  = req.last;

      if (req.opcode) begin
         cmd_out.is_clue = 1'b1;
      end else begin
         cmd_out.dict_clear = start;
         if (err_in == ST_OK) begin
            if (pos >= PW'(DICT_DEPTH)) begin
               err_in = ST_OVERFLOW;
            end else begin
               cmd_out.store_wr   = 1'b1;
               cmd_out.store_addr = ADDR_W'(pos[AW-1:0]);
               pos_in             = pos + PW'(1);
               if (pos == '0) begin
                  count_in = b;
                  if (b > 8'(MAX_TOKENS)) begin
                     err_in = ST_TOO_MANY;
                  end
               end else if (left_in != '0) begin
                  left_in = left_in - LW'(1);
               end else if (parsed_in < count_in) begin
                  if (b > 8'(MAX_ENTRY_LEN)) begin
                     err_in = ST_TOO_LONG;
                  end else begin
                     cmd_out.entry_wr  = 1'b1;
                     cmd_out.entry_idx = IDX_W'(parsed_in);
                     cmd_out.entry_off = ADDR_W'(pos + PW'(1));
                     cmd_out.entry_len = LEN_W'(b);
                     left_in           = LW'(b);
                     parsed_in         = parsed_in + 8'd1;
                  end
               end
            end
         end
         if (req.last) begin
            status = err_in;
            if (status == ST_OK && (parsed_in < count_in || left_in != '0)) begin
               status = ST_TRUNC;
            end
            cmd_out.status_vld = 1'b1;
            cmd_out.status     = status;
            cmd_out.new_count  = (status == ST_OK) ? count_in : 8'd0;
            pos_in             = '0;
            parsed_in          = '0;
            left_in            = '0;
            err_in             = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         parsed_ff <= '0;
         left_ff   <= '0;
         err_ff    <= ST_OK;
         count_ff  <= '0;
      end else if (push && !req.opcode) begin
         pos_ff    <= pos_in;
         parsed_ff <= parsed_in;
         left_ff   <= left_in;
         err_ff    <= err_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/dte_fifo.sv
// ----------------------------------------------------------------------------
// dte_fifo: command queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dte_fifo
   import dte_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  dte_cmd_type push_data,
   output logic        full,
   input  logic        pop,
   output dte_cmd_type head,
   output logic        head_valid
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   dte_cmd_type   slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      logic [PW-1:0] n;
      n = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
      return n;
   endfunction

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

// File: rtl/dte_back.sv
// ----------------------------------------------------------------------------
// dte_back: dictionary store and expansion engine
// Holds the store and entry tables, executes commands, drives the results.
// ----------------------------------------------------------------------------
module dte_back
   import dte_pkg::*;
#(
   parameter int DICT_DEPTH    = DICT_DEPTH_DEF,
   parameter int MAX_TOKENS    = MAX_TOKENS_DEF,
   parameter int MAX_ENTRY_LEN = MAX_ENTRY_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   input  dte_cmd_type        cmd,
   input  logic               cmd_valid,
   output logic               cmd_pop,
   dte_rsp_if.source          rsp
);

   localparam int AW = $clog2(DICT_DEPTH);
   localparam int TW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
   localparam int LW = $clog2(MAX_ENTRY_LEN + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_TAB  = 5'b00010,
      S_RD   = 5'b00100,
      S_BYTE = 5'b01000,
      S_MARK = 5'b10000
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] out_count_ff, out_count_in;
   logic [7:0]         entry_count_ff, entry_count_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [LW-1:0]      left_ff, left_in;
   logic               last_ff, last_in;

   logic [7:0]         store_mem [DICT_DEPTH];
   logic [AW-1:0]      off_mem [MAX_TOKENS];
   logic [LW-1:0]      len_mem [MAX_TOKENS];
   logic [7:0]         store_q;
   logic [AW-1:0]      off_q;
   logic [LW-1:0]      len_q;

   logic               rsp_valid_ff;
   logic [7:0]         byte_ff;
   logic               has_ff, eoc_ff, sv_ff, lor_ff;
   load_status_type    st_ff;

   logic               out_free, out_load;
   logic [7:0]         e_byte;
   logic               e_has, e_eoc, e_sv, e_lor;
   load_status_type    e_st;

   logic [LIMIT_W-1:0] cnt_eff;
   logic               room, is_tok, tok_ok, need_out, byte_fin;
   logic               load_wr;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign cnt_eff  = cmd.first ? '0 : out_count_ff;
   assign room     = cnt_eff < limit_ff;
   assign is_tok   = cmd.data[7];
   assign tok_ok   = {1'b0, cmd.data[6:0]} < entry_count_ff;
   assign need_out = cmd.is_clue ? (room && !is_tok) : cmd.status_vld;
   assign cmd_pop  = cmd_valid && (state_ff == S_IDLE) && (!need_out || out_free);
   assign load_wr  = cmd_pop && !cmd.is_clue;
   assign byte_fin = (left_ff == LW'(1)) ||
                     ({1'b0, out_count_ff} + (LIMIT_W + 1)'(1) == {1'b0, limit_ff});

   always_comb begin
      state_in       = state_ff;
      out_count_in   = out_count_ff;
      entry_count_in = entry_count_ff;
      addr_in        = addr_ff;
      left_in        = left_ff;
      last_in        = last_ff;
      out_load       = 1'b0;
      e_byte         = '0;
      e_has          = 1'b0;
      e_eoc          = 1'b0;
      e_st           = ST_OK;
      e_sv           = 1'b0;
      e_lor          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               if (!cmd.is_clue) begin
                  if (cmd.dict_clear) begin
                     entry_count_in = '0;
                  end
                  if (cmd.status_vld) begin
                     entry_count_in = cmd.new_count;
                     out_load       = 1'b1;
                     e_st           = cmd.status;
                     e_sv           = 1'b1;
                     e_lor          = 1'b1;
                  end
               end else begin
                  out_count_in = cnt_eff;
                  last_in      = cmd.last;
                  if (room && !is_tok) begin
                     out_load     = 1'b1;
                     e_byte       = cmd.data;
                     e_has        = 1'b1;
                     e_eoc        = cmd.last;
                     e_lor        = 1'b1;
                     out_count_in = cnt_eff + LIMIT_W'(1);
                  end else if (room && tok_ok) begin
                     state_in = S_TAB;
                  end else if (cmd.last) begin
                     state_in = S_MARK;
                  end
               end
            end
         end
         S_TAB: begin
            if (len_q == '0) begin
               state_in = last_ff ? S_MARK : S_IDLE;
            end else begin
               addr_in  = off_q;
               left_in  = len_q;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_BYTE;
         end
         S_BYTE: begin
            if (out_free) begin
               out_load     = 1'b1;
               e_byte       = store_q;
               e_has        = 1'b1;
               e_eoc        = byte_fin && last_ff;
               e_lor        = byte_fin;
               out_count_in = out_count_ff + LIMIT_W'(1);
               if (byte_fin) begin
                  state_in = S_IDLE;
               end else begin
                  addr_in  = addr_ff + AW'(1);
                  left_in  = left_ff - LW'(1);
                  state_in = S_RD;
               end
            end
         end
         S_MARK: begin
            if (out_free) begin
               out_load = 1'b1;
               e_eoc    = 1'b1;
               e_lor    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // store: written by blob commands, read one byte per access while expanding
   always_ff @(posedge clock) begin
      if (load_wr && cmd.store_wr) begin
         store_mem[cmd.store_addr[AW-1:0]] <= cmd.data;
      end
      store_q <= store_mem[addr_ff];
   end

   // entry tables: looked up with the token index of the command being popped
   always_ff @(posedge clock) begin
      if (load_wr && cmd.entry_wr) begin
         off_mem[cmd.entry_idx[TW-1:0]] <= cmd.entry_off[AW-1:0];
         len_mem[cmd.entry_idx[TW-1:0]] <= cmd.entry_len[LW-1:0];
      end
      off_q <= off_mem[cmd.data[TW-1:0]];
      len_q <= len_mem[cmd.data[TW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         limit_ff       <= LIMIT_RESET;
         out_count_ff   <= '0;
         entry_count_ff <= '0;
         left_ff        <= '0;
         last_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         out_count_ff   <= out_count_in;
         entry_count_ff <= entry_count_in;
         left_ff        <= left_in;
         last_ff        <= last_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (out_load) begin
         byte_ff <= e_byte;
         has_ff  <= e_has;
         eoc_ff  <= e_eoc;
         st_ff   <= e_st;
         sv_ff   <= e_sv;
         lor_ff  <= e_lor;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_byte     = byte_ff;
   assign rsp.has_byte     = has_ff;
   assign rsp.end_of_clue  = eoc_ff;
   assign rsp.load_status  = st_ff;
   assign rsp.status_valid = sv_ff;
   assign rsp.last_of_run  = lor_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("back end state is not one-hot");

   a_byte_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BYTE) |-> (left_ff != '0))
      else $error("byte emission with no bytes left in entry");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp.ready))
      else $error("result register overwritten before it was taken");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= 8'(MAX_TOKENS))
      else $error("entry count beyond token limit");

   a_tab_follows_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAB) |-> $past(cmd_pop))
      else $error("table lookup without a popped token command");

endmodule

// File: rtl/dictionary_token_expander_top.sv
// ----------------------------------------------------------------------------
// dictionary_token_expander_top: dictionary token expander
// Loads a dictionary blob, then expands clue bytes into dictionary text.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch   valid/ready input; opcode 0 carries a blob byte, opcode 1 a clue
//            byte. first restarts a blob or clue, last closes it.
//   rsp_ch   valid/ready output; one item per expanded byte, one status item
//            on a blob's last byte, one bare marker on a clue's last byte
//            that emitted nothing.
//   csr_*    write of the per-clue output limit; write only while idle.
// A literal or status goes via the queue and result register to rsp_ch. A
//   token reads its entry tables in S_TAB, then S_RD and S_BYTE per text
//   byte (one store read port, registered data). Literals and blob bytes
//   sustain one item per cycle while no token expands and rsp_ch is ready.
// A four-entry command queue sits between intake and expansion, so req_ch
//   keeps taking items while a token is expanding or rsp_ch is stalled;
//   req_ch.ready drops only when that queue is full.
// Reset: the dictionary is empty and the limit is 255. Store contents are
//   left as they are; no clearing pass runs and items are taken right away.
// ----------------------------------------------------------------------------
module dictionary_token_expander_top
   import dte_pkg::*;
#(
   parameter int DICT_DEPTH    = DICT_DEPTH_DEF,
   parameter int MAX_TOKENS    = MAX_TOKENS_DEF,
   parameter int MAX_ENTRY_LEN = MAX_ENTRY_LEN_DEF,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   dte_req_if.sink            req_ch,
   dte_rsp_if.source          rsp_ch
);

   dte_cmd_type push_cmd, head_cmd;
   logic        push, q_full, head_valid, pop;

   // intake: parse blob bytes, classify clue bytes
   dte_front #(
      .DICT_DEPTH    (DICT_DEPTH),
      .MAX_TOKENS    (MAX_TOKENS),
      .MAX_ENTRY_LEN (MAX_ENTRY_LEN)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .q_full  (q_full),
      .push    (push),
      .cmd_out (push_cmd)
   );

   // hold commands so intake and expansion stall independently
   dte_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head       (head_cmd),
      .head_valid (head_valid)
   );

   // execute: store writes, table lookups, byte emission
   dte_back #(
      .DICT_DEPTH    (DICT_DEPTH),
      .MAX_TOKENS    (MAX_TOKENS),
      .MAX_ENTRY_LEN (MAX_ENTRY_LEN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (head_cmd),
      .cmd_valid   (head_valid),
      .cmd_pop     (pop),
      .rsp         (rsp_ch)
   );

endmodule
